[rtl/dqe_pkg.sv]
// dqe_pkg: shared constants, command and status codes, and the cell control struct
// for the double-ended queue. Depends on nothing.
package dqe_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DATA_W           = 32;
    localparam int CMD_W            = 2;
    localparam int ST_W             = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // broadcast to every cell: one command that really changes the contents
    typedef struct packed {
        logic             en;
        logic [CMD_W-1:0] cmd;
    } dqe_op_t;

endpackage

[rtl/dqe_cell.sv]
// dqe_cell: one entry of the queue, ordered from the front, shifting with its neighbors.
// Depends on dqe_pkg.
module dqe_cell #(
    parameter int INDEX    = 0,
    parameter int CAPACITY = dqe_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                               clk,
    input  dqe_pkg::dqe_op_t                   op,
    input  logic [CNT_W-1:0]                   count,
    input  logic signed [dqe_pkg::DATA_W-1:0]  prev_data,
    input  logic signed [dqe_pkg::DATA_W-1:0]  next_data,
    input  logic signed [dqe_pkg::DATA_W-1:0]  push_value,
    output logic signed [dqe_pkg::DATA_W-1:0]  data
);
    import dqe_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     at_tail;

    // first free slot behind the back entry
    assign at_tail = (count == CNT_W'(INDEX));

    always_comb
    begin
        data_next = data_reg;
        if (op.en)
        begin
            case (op.cmd)
                CMD_PUSH_FRONT: data_next = (INDEX == 0) ? push_value : prev_data;
                CMD_PUSH_BACK:  if (at_tail) data_next = push_value;
                CMD_POP_FRONT:  data_next = next_data;
                default:        data_next = data_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/double_ended_queue.sv]
// double_ended_queue: top level, a row of dqe_cell entries plus count and result register.
// Depends on dqe_pkg and dqe_cell.
//
// Fixed-capacity double-ended queue of signed 32-bit values. Entries sit in a row of
// CAPACITY cells ordered from the front: cell 0 always holds the front entry and cell
// occupancy-1 the back entry. A push at the front shifts every cell one place toward
// the back and loads cell 0; a pop at the front shifts every cell one place toward the
// front; a push at the back loads the first free cell; a pop at the back just reads
// cell occupancy-1 and drops the count. Every accepted command gives exactly one result
// transfer carrying popped_value (zero unless a pop succeeded), status (done, full or
// empty) and the occupancy after the command. A push while full or a pop while empty
// changes nothing. It takes one command per clock while in_stall is low: the whole row
// shifts together and the back entry is read through one selector over the cells; the result
// waits in an output register, and in_stall is raised only while that register holds
// a result the consumer is stalling. No clearing pass: cell contents are undefined
// until written and are never read before that.
module double_ended_queue #(
    parameter int CAPACITY = dqe_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [dqe_pkg::CMD_W-1:0]          command,
    input  logic signed [dqe_pkg::DATA_W-1:0]  push_value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [dqe_pkg::DATA_W-1:0]  popped_value,
    output logic [dqe_pkg::ST_W-1:0]           status,
    output logic [CNT_W-1:0]                   occupancy
);
    import dqe_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // count and result register
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;
    logic [ST_W-1:0]          status_reg;
    logic [ST_W-1:0]          status_next;

    logic                     accept;
    logic                     is_push;
    logic                     full;
    logic                     empty;
    dqe_op_t                  op;
    logic [CNT_W-1:0]         back_pos;
    logic signed [DATA_W-1:0] back_data;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    // a new command transfers unless a finished result is being held back
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign is_push = (command == CMD_PUSH_FRONT) || (command == CMD_PUSH_BACK);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    // only commands that change the contents reach the cells
    assign op.en  = accept && (is_push ? !full : !empty);
    assign op.cmd = command;

    // back entry position, only meaningful when not empty
    assign back_pos  = count_reg - CNT_W'(1);
    assign back_data = cell_data[back_pos[IDX_W-1:0]];

    // row of cells, each fed by its neighbors; cell 0 sees push_value, the last cell its own data
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] prev_d;
        logic signed [DATA_W-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = push_value;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_d = cell_data[i];
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end

        dqe_cell #(
            .INDEX    (i),
            .CAPACITY (CAPACITY),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .count      (count_reg),
            .prev_data  (prev_d),
            .next_data  (next_d),
            .push_value (push_value),
            .data       (cell_data[i])
        );
    end

    // result and count for the accepted command
    always_comb
    begin
        count_next     = count_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
            popped_next    = '0;
            status_next    = ST_DONE;
            case (command)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        popped_next = cell_data[0];
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        popped_next = back_data;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    logic [CNT_W-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        if (accept)
            occ_reg <= count_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

endmodule

[rtl/dqe_checker.sv]
// dqe_checker: port-level assertions for double_ended_queue, bound to the top level.
// Depends on dqe_pkg and double_ended_queue.
module dqe_checker #(
    parameter int CAPACITY = dqe_pkg::DEFAULT_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic [dqe_pkg::CMD_W-1:0]          command,
    input logic signed [dqe_pkg::DATA_W-1:0]  push_value,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [dqe_pkg::DATA_W-1:0]  popped_value,
    input logic [dqe_pkg::ST_W-1:0]           status,
    input logic [CNT_W-1:0]                   occupancy
);
    import dqe_pkg::*;

    // occupancy never beyond capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= CNT_W'(CAPACITY)))
        else $error("occupancy beyond capacity");

    // refused push only when full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (occupancy == CNT_W'(CAPACITY)
            && popped_value == '0))
        else $error("full status with room left");

    // refused pop only when empty, and returns zero
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EMPTY) |-> (occupancy == '0 && popped_value == '0))
        else $error("empty status with entries held");

    // a stalled command stays put until it transfers
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(command)
            && $stable(push_value)))
        else $error("stalled command changed");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(popped_value)
            && $stable(status) && $stable(occupancy)))
        else $error("stalled result changed");

endmodule

bind double_ended_queue dqe_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_dqe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy)
);
